// ===== design/intc4t_pkg.sv =====
// package for the four-timer interrupt controller
// register indexes, input kinds, result struct, timer channel map, prescale table and winner search
package intc4t_pkg;

  typedef enum logic [2:0] {
    KIND_READ  = 3'd0,
    KIND_WRITE = 3'd1,
    KIND_TICK  = 3'd2,
    KIND_PIN_A = 3'd3,
    KIND_PIN_B = 3'd4,
    KIND_ACK   = 3'd5
  } kind_t;

  localparam logic [4:0] REG_GPIP  = 5'd0;
  localparam logic [4:0] REG_AER   = 5'd1;
  localparam logic [4:0] REG_DDR   = 5'd2;
  localparam logic [4:0] REG_IERA  = 5'd3;
  localparam logic [4:0] REG_IERB  = 5'd4;
  localparam logic [4:0] REG_IPRA  = 5'd5;
  localparam logic [4:0] REG_IPRB  = 5'd6;
  localparam logic [4:0] REG_ISRA  = 5'd7;
  localparam logic [4:0] REG_ISRB  = 5'd8;
  localparam logic [4:0] REG_IMRA  = 5'd9;
  localparam logic [4:0] REG_IMRB  = 5'd10;
  localparam logic [4:0] REG_VR    = 5'd11;
  localparam logic [4:0] REG_TACR  = 5'd12;
  localparam logic [4:0] REG_TBCR  = 5'd13;
  localparam logic [4:0] REG_TCDCR = 5'd14;
  localparam logic [4:0] REG_TADR  = 5'd15;
  localparam logic [4:0] REG_TBDR  = 5'd16;
  localparam logic [4:0] REG_TCDR  = 5'd17;
  localparam logic [4:0] REG_TDDR  = 5'd18;

  localparam int NumTimers = 4;
  localparam logic [3:0] MODE_EVENT = 4'd8;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_request;
    logic       vector_valid;
    logic [7:0] vector_number;
    logic [3:0] timer_outputs;
    logic [7:0] gpio_out;
  } result_t;

  function automatic logic [3:0] timer_channel(input logic [1:0] t);
    case (t)
      2'd0:    timer_channel = 4'd13;
      2'd1:    timer_channel = 4'd8;
      2'd2:    timer_channel = 4'd5;
      default: timer_channel = 4'd4;
    endcase
  endfunction

  function automatic logic [7:0] prescale_div(input logic [2:0] m);
    case (m)
      3'd1:    prescale_div = 8'd4;
      3'd2:    prescale_div = 8'd10;
      3'd3:    prescale_div = 8'd16;
      3'd4:    prescale_div = 8'd50;
      3'd5:    prescale_div = 8'd64;
      3'd6:    prescale_div = 8'd100;
      3'd7:    prescale_div = 8'd200;
      default: prescale_div = 8'd0;
    endcase
  endfunction

  // highest channel set in both pending and mask above highest in-service; returns 16 (bit 4 set) if none
  function automatic logic [4:0] find_winner(input logic [15:0] pend, input logic [15:0] msk,
                                             input logic [15:0] svc);
    logic [15:0] above;
    logic [15:0] cand;
    logic        hit;
    logic [4:0]  res;
    above = 16'hffff;
    hit   = 1'b0;
    for (int i = 15; i >= 0; i--) begin
      if (!hit && svc[i]) begin
        hit   = 1'b1;
        above = 16'hffff << (i + 1);
      end
    end
    cand = pend & msk & above;
    res  = 5'd16;
    for (int i = 15; i >= 0; i--) begin
      if (res[4] && cand[i]) res = 5'(i);
    end
    return res;
  endfunction

endpackage

// ===== design/intc4t_core.sv =====
// controller state and single-pass update for one transfer
// depends on intc4t_pkg
module intc4t_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic [2:0]          kind,
  input  logic [4:0]          reg_index,
  input  logic [7:0]          write_data,
  input  logic                input_level,
  output intc4t_pkg::result_t res
);
  import intc4t_pkg::*;

  logic [7:0]  gpio_data, edge_select, direction, vector_base;
  logic [15:0] enable_bits, pending_bits, service_bits, mask_bits;
  logic [4:0]  timer_mode [NumTimers];
  logic [7:0]  timer_reload [NumTimers];
  logic [7:0]  timer_count [NumTimers];
  logic [7:0]  prescale_count [NumTimers];
  logic [3:0]  output_levels;
  logic [1:0]  last_inputs;

  logic [7:0]  gpio_data_next, edge_select_next, direction_next, vector_base_next;
  logic [15:0] enable_bits_next, pending_bits_next, service_bits_next, mask_bits_next;
  logic [4:0]  timer_mode_next [NumTimers];
  logic [7:0]  timer_reload_next [NumTimers];
  logic [7:0]  timer_count_next [NumTimers];
  logic [7:0]  prescale_count_next [NumTimers];
  logic [3:0]  output_levels_next;
  logic [1:0]  last_inputs_next;

  logic [3:0]  mode [NumTimers];
  logic [3:0]  delay;
  logic [3:0]  step;
  logic [7:0]  rd;
  logic [4:0]  win;
  logic [4:0]  win_after;
  logic [7:0]  pre_inc;
  logic        lvl_last;
  logic        rising;
  logic [1:0]  tsel;

  always_comb begin
    for (int t = 0; t < NumTimers; t++) begin
      mode[t]  = (t < 2) ? timer_mode[t][3:0] : {1'b0, timer_mode[t][2:0]};
      delay[t] = (mode[t] >= 4'd1) && (mode[t] <= 4'd7);
    end
  end

  always_comb begin
    case (reg_index)
      REG_GPIP:  rd = 8'h80 | (gpio_data & direction);
      REG_AER:   rd = edge_select;
      REG_DDR:   rd = direction;
      REG_IERA:  rd = enable_bits[15:8];
      REG_IERB:  rd = enable_bits[7:0];
      REG_IPRA:  rd = pending_bits[15:8];
      REG_IPRB:  rd = pending_bits[7:0];
      REG_ISRA:  rd = service_bits[15:8];
      REG_ISRB:  rd = service_bits[7:0];
      REG_IMRA:  rd = mask_bits[15:8];
      REG_IMRB:  rd = mask_bits[7:0];
      REG_VR:    rd = vector_base;
      REG_TACR:  rd = {3'd0, timer_mode[0]};
      REG_TBCR:  rd = {3'd0, timer_mode[1]};
      REG_TCDCR: rd = {1'b0, timer_mode[2][2:0], 1'b0, timer_mode[3][2:0]};
      REG_TADR:  rd = timer_count[0];
      REG_TBDR:  rd = timer_count[1];
      REG_TCDR:  rd = timer_count[2];
      REG_TDDR:  rd = timer_count[3];
      default:   rd = 8'd0;
    endcase
  end

  assign win = find_winner(pending_bits, mask_bits, service_bits);

  always_comb begin
    gpio_data_next     = gpio_data;
    edge_select_next   = edge_select;
    direction_next     = direction;
    vector_base_next   = vector_base;
    enable_bits_next   = enable_bits;
    pending_bits_next  = pending_bits;
    service_bits_next  = service_bits;
    mask_bits_next     = mask_bits;
    output_levels_next = output_levels;
    last_inputs_next   = last_inputs;
    timer_mode_next     = timer_mode;
    timer_reload_next   = timer_reload;
    timer_count_next    = timer_count;
    prescale_count_next = prescale_count;
    step     = 4'd0;
    pre_inc  = 8'd0;
    tsel     = (kind == KIND_PIN_B) ? 2'd1 : 2'd0;
    lvl_last = last_inputs[tsel[0]];
    rising   = (kind == KIND_PIN_B) ? edge_select[3] : edge_select[4];

    case (kind)
      KIND_WRITE: begin
        case (reg_index)
          REG_GPIP: gpio_data_next = write_data & direction;
          REG_AER:  edge_select_next = write_data;
          REG_DDR:  direction_next = write_data;
          REG_IERA: begin
            enable_bits_next  = {write_data, enable_bits[7:0]};
            pending_bits_next = pending_bits & {write_data, enable_bits[7:0]};
          end
          REG_IERB: begin
            enable_bits_next  = {enable_bits[15:8], write_data};
            pending_bits_next = pending_bits & {enable_bits[15:8], write_data};
          end
          REG_IPRA: pending_bits_next = pending_bits & {write_data, 8'hff};
          REG_IPRB: pending_bits_next = pending_bits & {8'hff, write_data};
          REG_ISRA: service_bits_next = {write_data, service_bits[7:0]};
          REG_ISRB: service_bits_next = {service_bits[15:8], write_data};
          REG_IMRA: mask_bits_next = {write_data, mask_bits[7:0]};
          REG_IMRB: mask_bits_next = {mask_bits[15:8], write_data};
          REG_VR: begin
            vector_base_next = write_data & 8'hf8;
            if (!write_data[3]) service_bits_next = 16'd0;
          end
          REG_TACR, REG_TBCR: begin
            tsel = (reg_index == REG_TBCR) ? 2'd1 : 2'd0;
            timer_mode_next[tsel]     = write_data[4:0];
            prescale_count_next[tsel] = 8'd0;
            if (write_data[4]) output_levels_next[tsel] = 1'b0;
          end
          REG_TCDCR: begin
            timer_mode_next[2]     = {2'd0, write_data[6:4]};
            timer_mode_next[3]     = {2'd0, write_data[2:0]};
            prescale_count_next[2] = 8'd0;
            prescale_count_next[3] = 8'd0;
          end
          REG_TADR, REG_TBDR, REG_TCDR, REG_TDDR: begin
            tsel = 2'(reg_index - REG_TADR);
            timer_reload_next[tsel] = write_data;
            if (!delay[tsel]) timer_count_next[tsel] = write_data;
          end
          default: ;
        endcase
      end
      KIND_TICK: begin
        for (int t = 0; t < NumTimers; t++) begin
          if (delay[t]) begin
            pre_inc = prescale_count[t] + 8'd1;
            if (pre_inc >= prescale_div(mode[t][2:0])) begin
              prescale_count_next[t] = 8'd0;
              step[t] = 1'b1;
            end else begin
              prescale_count_next[t] = pre_inc;
            end
          end
        end
      end
      KIND_PIN_A, KIND_PIN_B: begin
        if (mode[tsel] == MODE_EVENT) begin
          if (rising ? (!lvl_last && input_level) : (lvl_last && !input_level))
            step[tsel] = 1'b1;
          last_inputs_next[tsel[0]] = input_level;
        end
      end
      KIND_ACK: begin
        if (!win[4]) begin
          pending_bits_next[win[3:0]] = 1'b0;
          if (vector_base[3]) service_bits_next[win[3:0]] = 1'b1;
        end
      end
      default: ;
    endcase

    for (int t = 0; t < NumTimers; t++) begin
      if (step[t]) begin
        if (timer_count[t] == 8'd1) begin
          if (enable_bits[timer_channel(2'(t))])
            pending_bits_next[timer_channel(2'(t))] = 1'b1;
          output_levels_next[t] = ~output_levels[t];
          timer_count_next[t]   = timer_reload[t];
        end else begin
          timer_count_next[t] = timer_count[t] - 8'd1;
        end
      end
    end
  end

  assign win_after = find_winner(pending_bits_next, mask_bits_next, service_bits_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      gpio_data <= '0; edge_select <= '0; direction <= '0; vector_base <= '0;
      enable_bits <= '0; pending_bits <= '0; service_bits <= '0; mask_bits <= '0;
      output_levels <= '0; last_inputs <= '0;
      for (int t = 0; t < NumTimers; t++) begin
        timer_mode[t] <= '0; timer_reload[t] <= '0;
        timer_count[t] <= '0; prescale_count[t] <= '0;
      end
    end else if (go) begin
      gpio_data <= gpio_data_next; edge_select <= edge_select_next;
      direction <= direction_next; vector_base <= vector_base_next;
      enable_bits <= enable_bits_next; pending_bits <= pending_bits_next;
      service_bits <= service_bits_next; mask_bits <= mask_bits_next;
      output_levels <= output_levels_next; last_inputs <= last_inputs_next;
      timer_mode <= timer_mode_next; timer_reload <= timer_reload_next;
      timer_count <= timer_count_next; prescale_count <= prescale_count_next;
    end
  end

  always_comb begin
    res.read_data     = (kind == KIND_READ) ? rd : 8'd0;
    res.irq_request   = !win_after[4];
    res.vector_valid  = (kind == KIND_ACK) && !win[4];
    res.vector_number = res.vector_valid ? {vector_base[7:4], win[3:0]} : 8'd0;
    res.timer_outputs = output_levels_next;
    res.gpio_out      = gpio_data_next & direction_next;
  end

endmodule

// ===== design/interrupt_controller_with_four_timers.sv =====
// top level of the four-timer interrupt controller
// input register, core update and result register; depends on intc4t_pkg, intc4t_core
// One transfer per clock while the result side does not stall: a transfer waits in the
// input register, the core updates state and forms the result as the transfer leaves it,
// and the result register holds that result until taken. The input register and the
// result register lie between a transfer and its result. Core state and the valid flags
// reset to zero; the input and result data registers are not reset.
module interrupt_controller_with_four_timers (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] kind,
  input  logic [4:0] reg_index,
  input  logic [7:0] write_data,
  input  logic       input_level,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic       irq_request,
  output logic       vector_valid,
  output logic [7:0] vector_number,
  output logic [3:0] timer_outputs,
  output logic [7:0] gpio_out
);
  import intc4t_pkg::*;

  logic       stage_valid;
  logic [2:0] stage_kind;
  logic [4:0] stage_reg_index;
  logic [7:0] stage_write_data;
  logic       stage_level;
  logic       go;
  result_t    res;
  result_t    out_reg;

  assign go       = stage_valid && (!out_valid || !out_stall);
  assign in_stall = stage_valid && !go;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      stage_kind       <= kind;
      stage_reg_index  <= reg_index;
      stage_write_data <= write_data;
      stage_level      <= input_level;
    end
  end

  intc4t_core u_core (
    .clk        (clk),
    .rst        (rst),
    .go         (go),
    .kind       (stage_kind),
    .reg_index  (stage_reg_index),
    .write_data (stage_write_data),
    .input_level(stage_level),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) out_reg <= res;
  end

  assign read_data     = out_reg.read_data;
  assign irq_request   = out_reg.irq_request;
  assign vector_valid  = out_reg.vector_valid;
  assign vector_number = out_reg.vector_number;
  assign timer_outputs = out_reg.timer_outputs;
  assign gpio_out      = out_reg.gpio_out;

endmodule
